@@ hw/rtl/stq_pkg.sv @@
package stq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int SLOT_W      = 4;
  localparam int FIRE_LIMIT  = 16;
  localparam int FIRE_W      = $clog2(FIRE_LIMIT + 1);

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_CANCEL = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_BADINT    = 3'd2;
  localparam logic [2:0] ST_CANCELLED = 3'd3;
  localparam logic [2:0] ST_NOTFOUND  = 3'd4;
  localparam logic [2:0] ST_FIRED     = 3'd5;
  localparam logic [2:0] ST_NONEDUE   = 3'd6;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [15:0]       interval;
    logic [7:0]        action;
    logic [31:0]       tag;
    logic [SLOT_W-1:0] handle;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [SLOT_W-1:0] slot;
    logic [7:0]        fired_action;
    logic [31:0]       fired_tag;
    logic              last;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISP,
    S_FREE,
    S_SRCH_RD,
    S_SRCH_DL,
    S_SRCH_CMP,
    S_INS_RD,
    S_INS_WR,
    S_CSRCH_RD,
    S_CSRCH_CMP,
    S_SH_RD,
    S_SH_WR,
    S_CAN_END,
    S_TK_CHK,
    S_TK_DL,
    S_TK_CMP
  } ctl_state_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_BADINT,
    OP_FULL,
    OP_NOTFOUND,
    OP_FREE_STEP,
    OP_ORD_RD,
    OP_ORD_RD0,
    OP_DL_RD,
    OP_IDX_INC,
    OP_INS_WR,
    OP_INS_LAST,
    OP_SH_WR,
    OP_CNT_DEC,
    OP_CAN_DONE,
    OP_TICK,
    OP_FIRE,
    OP_TK_END
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } stq_cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       interval_zero;
    logic       count_full;
    logic       count_zero;
    logic       handle_ok;
    logic       idx_at_depth;
    logic       idx_at_count;
    logic       free_hit;
    logic       dl_before;
    logic       ord_hit;
    logic       not_due;
    logic       fire_limit;
  } stq_sts_t;

  // True when a lies strictly before b on the wrapping 32-bit time line.
  function automatic logic serial_before(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] diff;
    diff = a - b;
    return diff[31];
  endfunction

endpackage

@@ hw/rtl/stq_ctrl.sv @@
module stq_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  stq_pkg::stq_sts_t sts,
  output stq_pkg::stq_cmd_t cmd
);
  import stq_pkg::*;

  ctl_state_t state_r;
  ctl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_DISP;
      end
      S_DISP: begin
        unique case (sts.req_type)
          REQ_INSERT: begin
            if (sts.interval_zero || sts.count_full) state_nxt = S_IDLE;
            else state_nxt = S_FREE;
          end
          REQ_CANCEL: begin
            if (sts.handle_ok) state_nxt = S_CSRCH_RD;
            else state_nxt = S_IDLE;
          end
          REQ_TICK: state_nxt = S_TK_CHK;
          default:  state_nxt = S_IDLE;
        endcase
      end
      S_FREE: begin
        if (sts.idx_at_depth) state_nxt = S_IDLE;
        else if (sts.free_hit) state_nxt = S_SRCH_RD;
      end
      S_SRCH_RD: begin
        if (sts.idx_at_count) state_nxt = S_INS_RD;
        else state_nxt = S_SRCH_DL;
      end
      S_SRCH_DL:  state_nxt = S_SRCH_CMP;
      S_SRCH_CMP: begin
        if (sts.dl_before) state_nxt = S_SRCH_RD;
        else state_nxt = S_INS_RD;
      end
      S_INS_RD: begin
        if (sts.idx_at_count) state_nxt = S_IDLE;
        else state_nxt = S_INS_WR;
      end
      S_INS_WR: state_nxt = S_INS_RD;
      S_CSRCH_RD: begin
        if (sts.idx_at_count) state_nxt = S_IDLE;
        else state_nxt = S_CSRCH_CMP;
      end
      S_CSRCH_CMP: begin
        if (sts.ord_hit) state_nxt = S_SH_RD;
        else state_nxt = S_CSRCH_RD;
      end
      S_SH_RD: begin
        if (sts.idx_at_count) begin
          if (sts.req_type == REQ_TICK) state_nxt = S_TK_CHK;
          else state_nxt = S_CAN_END;
        end else begin
          state_nxt = S_SH_WR;
        end
      end
      S_SH_WR:   state_nxt = S_SH_RD;
      S_CAN_END: state_nxt = S_IDLE;
      S_TK_CHK: begin
        if (sts.count_zero || sts.fire_limit) state_nxt = S_IDLE;
        else state_nxt = S_TK_DL;
      end
      S_TK_DL: state_nxt = S_TK_CMP;
      S_TK_CMP: begin
        if (sts.not_due) state_nxt = S_IDLE;
        else state_nxt = S_SH_RD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (start) cmd.op = OP_LOAD;
      end
      S_DISP: begin
        unique case (sts.req_type)
          REQ_INSERT: begin
            if (sts.interval_zero) cmd.op = OP_BADINT;
            else if (sts.count_full) cmd.op = OP_FULL;
          end
          REQ_CANCEL: begin
            if (!sts.handle_ok) cmd.op = OP_NOTFOUND;
          end
          REQ_TICK: cmd.op = OP_TICK;
          default:  cmd.op = OP_NONE;
        endcase
      end
      S_FREE: begin
        if (sts.idx_at_depth) cmd.op = OP_FULL;
        else cmd.op = OP_FREE_STEP;
      end
      S_SRCH_RD: begin
        if (!sts.idx_at_count) cmd.op = OP_ORD_RD;
      end
      S_SRCH_DL: cmd.op = OP_DL_RD;
      S_SRCH_CMP: begin
        if (sts.dl_before) cmd.op = OP_IDX_INC;
      end
      S_INS_RD: begin
        if (sts.idx_at_count) cmd.op = OP_INS_LAST;
        else cmd.op = OP_ORD_RD;
      end
      S_INS_WR: cmd.op = OP_INS_WR;
      S_CSRCH_RD: begin
        // A slot marked in use but absent from the order list is simply released.
        if (sts.idx_at_count) cmd.op = OP_CAN_DONE;
        else cmd.op = OP_ORD_RD;
      end
      S_CSRCH_CMP: cmd.op = OP_IDX_INC;
      S_SH_RD: begin
        if (sts.idx_at_count) cmd.op = OP_CNT_DEC;
        else cmd.op = OP_ORD_RD;
      end
      S_SH_WR:   cmd.op = OP_SH_WR;
      S_CAN_END: cmd.op = OP_CAN_DONE;
      S_TK_CHK: begin
        if (sts.count_zero || sts.fire_limit) cmd.op = OP_TK_END;
        else cmd.op = OP_ORD_RD0;
      end
      S_TK_DL: cmd.op = OP_DL_RD;
      S_TK_CMP: begin
        if (sts.not_due) cmd.op = OP_TK_END;
        else cmd.op = OP_FIRE;
      end
      default: cmd.op = OP_NONE;
    endcase
  end

endmodule

@@ hw/rtl/stq_dp.sv @@
module stq_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  stq_pkg::in_item_t  in_item,
  input  stq_pkg::stq_cmd_t  cmd,
  output stq_pkg::stq_sts_t  sts,
  output logic               out_strobe,
  output stq_pkg::out_item_t out_item
);
  import stq_pkg::*;

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // Order list and per-slot event stores.
  logic [IW-1:0] order_mem [QUEUE_DEPTH];
  logic [31:0]   dl_mem    [QUEUE_DEPTH];
  logic [7:0]    act_mem   [QUEUE_DEPTH];
  logic [31:0]   tag_mem   [QUEUE_DEPTH];

  logic [IW-1:0] order_q;
  logic [31:0]   dl_q;
  logic [7:0]    act_q;
  logic [31:0]   tag_q;

  logic [31:0]            time_r, time_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [CW-1:0]          idx_r, idx_nxt;
  logic [QUEUE_DEPTH-1:0] in_use_r, in_use_nxt;
  logic [FIRE_W-1:0]      fire_n_r, fire_n_nxt;
  logic                   pend_vld_r, pend_vld_nxt;
  logic                   out_strobe_r;

  in_item_t      req_r;
  logic [31:0]   dl_r;
  logic [IW-1:0] new_slot_r;
  logic [IW-1:0] carry_r;
  logic [IW-1:0] slot_r;
  out_item_t     pend_r;
  out_item_t     out_item_r;

  logic [IW-1:0] idx_lo;
  logic [IW-1:0] hidx;
  logic          free_hit;
  logic          idx_at_depth;

  logic          ord_we;
  logic [IW-1:0] ord_wa;
  logic [IW-1:0] ord_wd;

  logic          emit;
  out_item_t     emit_item;

  assign idx_lo       = idx_r[IW-1:0];
  assign hidx         = IW'(req_r.handle);
  assign idx_at_depth = (int'(idx_r) == QUEUE_DEPTH);
  assign free_hit     = !idx_at_depth && !in_use_r[idx_lo];

  always_comb begin
    sts.req_type      = req_r.req_type;
    sts.interval_zero = (req_r.interval == '0);
    sts.count_full    = (int'(count_r) >= QUEUE_DEPTH);
    sts.count_zero    = (count_r == '0);
    sts.handle_ok     = (int'(req_r.handle) < QUEUE_DEPTH) && in_use_r[hidx];
    sts.idx_at_depth  = idx_at_depth;
    sts.idx_at_count  = (idx_r == count_r);
    sts.free_hit      = free_hit;
    sts.dl_before     = serial_before(dl_q, dl_r);
    sts.ord_hit       = (order_q == hidx);
    sts.not_due       = serial_before(time_r, dl_q);
    sts.fire_limit    = (fire_n_r == FIRE_W'(FIRE_LIMIT));
  end

  always_comb begin
    ord_we = 1'b0;
    ord_wa = idx_lo;
    ord_wd = carry_r;
    case (cmd.op) inside
      OP_INS_WR, OP_INS_LAST: ord_we = 1'b1;
      OP_SH_WR: begin
        ord_we = 1'b1;
        ord_wa = IW'(idx_r - 1'b1);
        ord_wd = order_q;
      end
      default: ord_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ord_we) order_mem[ord_wa] <= ord_wd;
    if (cmd.op == OP_ORD_RD) order_q <= order_mem[idx_lo];
    else if (cmd.op == OP_ORD_RD0) order_q <= order_mem[0];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_INS_LAST) begin
      dl_mem[new_slot_r]  <= dl_r;
      act_mem[new_slot_r] <= req_r.action;
      tag_mem[new_slot_r] <= req_r.tag;
    end
    if (cmd.op == OP_DL_RD) begin
      dl_q  <= dl_mem[order_q];
      act_q <= act_mem[order_q];
      tag_q <= tag_mem[order_q];
    end
  end

  always_comb begin
    time_nxt     = time_r;
    count_nxt    = count_r;
    idx_nxt      = idx_r;
    in_use_nxt   = in_use_r;
    fire_n_nxt   = fire_n_r;
    pend_vld_nxt = pend_vld_r;
    case (cmd.op) inside
      OP_LOAD: begin
        idx_nxt      = '0;
        fire_n_nxt   = '0;
        pend_vld_nxt = 1'b0;
      end
      OP_FREE_STEP: idx_nxt = free_hit ? '0 : idx_r + 1'b1;
      OP_IDX_INC, OP_INS_WR, OP_SH_WR: idx_nxt = idx_r + 1'b1;
      OP_ORD_RD0: idx_nxt = CW'(1);
      OP_INS_LAST: begin
        count_nxt              = count_r + 1'b1;
        in_use_nxt[new_slot_r] = 1'b1;
      end
      OP_CNT_DEC:  count_nxt = count_r - 1'b1;
      OP_CAN_DONE: in_use_nxt[hidx] = 1'b0;
      OP_TICK:     time_nxt = time_r + 32'd1;
      OP_FIRE: begin
        in_use_nxt[slot_r] = 1'b0;
        fire_n_nxt         = fire_n_r + 1'b1;
        pend_vld_nxt       = 1'b1;
      end
      OP_TK_END: pend_vld_nxt = 1'b0;
      default: idx_nxt = idx_r;
    endcase
  end

  // A fired event is held back one step so that the last one can be marked.
  always_comb begin
    emit      = 1'b0;
    emit_item = '0;
    emit_item.last = 1'b1;
    case (cmd.op)
      OP_BADINT: begin
        emit             = 1'b1;
        emit_item.status = ST_BADINT;
      end
      OP_FULL: begin
        emit             = 1'b1;
        emit_item.status = ST_FULL;
      end
      OP_NOTFOUND: begin
        emit             = 1'b1;
        emit_item.status = ST_NOTFOUND;
      end
      OP_INS_LAST: begin
        emit             = 1'b1;
        emit_item.status = ST_INSERTED;
        emit_item.slot   = SLOT_W'(new_slot_r);
      end
      OP_CAN_DONE: begin
        emit             = 1'b1;
        emit_item.status = ST_CANCELLED;
        emit_item.slot   = req_r.handle;
      end
      OP_FIRE: begin
        emit      = pend_vld_r;
        emit_item = pend_r;
      end
      OP_TK_END: begin
        emit = 1'b1;
        if (pend_vld_r) begin
          emit_item      = pend_r;
          emit_item.last = 1'b1;
        end else begin
          emit_item.status = ST_NONEDUE;
        end
      end
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r       <= '0;
      count_r      <= '0;
      idx_r        <= '0;
      in_use_r     <= '0;
      fire_n_r     <= '0;
      pend_vld_r   <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      time_r       <= time_nxt;
      count_r      <= count_nxt;
      idx_r        <= idx_nxt;
      in_use_r     <= in_use_nxt;
      fire_n_r     <= fire_n_nxt;
      pend_vld_r   <= pend_vld_nxt;
      out_strobe_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      req_r <= in_item;
      dl_r  <= time_r + 32'(in_item.interval);
    end
    if (cmd.op == OP_FREE_STEP && free_hit) begin
      new_slot_r <= idx_lo;
      carry_r    <= idx_lo;
    end else if (cmd.op == OP_INS_WR) begin
      carry_r <= order_q;
    end
    if (cmd.op == OP_DL_RD) slot_r <= order_q;
    if (cmd.op == OP_FIRE) begin
      pend_r.status       <= ST_FIRED;
      pend_r.slot         <= SLOT_W'(slot_r);
      pend_r.fired_action <= act_q;
      pend_r.fired_tag    <= tag_q;
      pend_r.last         <= 1'b0;
    end
    if (emit) out_item_r <= emit_item;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

@@ hw/rtl/sorted_timer_event_queue.sv @@
// Sequential: one request at a time; busy is high from the accepting edge until it is done.
// Insert finds the lowest free slot, walks the order list past the entries due strictly
// earlier, then shifts the rest up one place; a cancel searches and closes the gap behind it.
// Tick advances time and fires due events from the head, at most FIRE_LIMIT per tick.
// Each result is on out_strobe for one cycle, in the cycle after the step that makes it; the
// receiver cannot stall. Synchronous active-low reset clears time, count and slot-in-use bits.
module sorted_timer_event_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  stq_pkg::in_item_t  in_item,
  output logic               out_strobe,
  output stq_pkg::out_item_t out_item
);
  import stq_pkg::*;

  stq_cmd_t cmd;
  stq_sts_t sts;

  stq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  stq_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cmd        (cmd),
    .sts        (sts),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

@@ dv/timer_queue_checker.sv @@
module timer_queue_checker #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  stq_pkg::in_item_t  in_item,
  input  logic               out_strobe,
  input  stq_pkg::out_item_t out_item,
  output int                 mismatch_count,
  output int                 outstanding,
  output int                 checked_count,
  output int                 fired_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import stq_pkg::*;

  // Shadow copy of the event queue.
  logic [31:0]       now_ticks;
  logic [31:0]       deadline_of [DEPTH];
  logic [7:0]        action_of [DEPTH];
  logic [31:0]       tag_of [DEPTH];
  logic [DEPTH-1:0]  slot_taken;
  logic [SLOT_W-1:0] due_order [DEPTH];
  int                queued;
  out_item_t         expected_results [$];

  // Wrap-safe ordering: a lies before b when the 32-bit difference is negative.
  function automatic logic due_earlier(input logic [31:0] a, input logic [31:0] b);
    return $signed(a - b) < 0;
  endfunction

  function automatic out_item_t result_of(input logic [2:0] status,
                                          input logic [SLOT_W-1:0] slot,
                                          input logic [7:0] act,
                                          input logic [31:0] arg,
                                          input logic last);
    out_item_t r;
    r.status       = status;
    r.slot         = slot;
    r.fired_action = act;
    r.fired_tag    = arg;
    r.last         = last;
    return r;
  endfunction

  task automatic predict_results(input in_item_t req);
    out_item_t         held;
    logic [31:0]       due;
    logic [SLOT_W-1:0] head;
    logic              stop;
    int                pos;
    int                free;
    int                fires;
    int                i;
    case (req.req_type)
      REQ_INSERT: begin
        free = DEPTH;
        for (i = DEPTH - 1; i >= 0; i--)
          if (!slot_taken[i]) free = i;
        if (req.interval == '0) begin
          expected_results.push_back(result_of(ST_BADINT, '0, '0, '0, 1'b1));
        end else if (queued >= DEPTH || free == DEPTH) begin
          expected_results.push_back(result_of(ST_FULL, '0, '0, '0, 1'b1));
        end else begin
          due = now_ticks + req.interval;
          // The new event goes ahead of every entry due at the same time or later.
          pos = 0;
          while (pos < queued && due_earlier(deadline_of[due_order[pos]], due)) pos++;
          for (i = queued; i > pos; i--) due_order[i] = due_order[i - 1];
          due_order[pos]    = SLOT_W'(free);
          queued++;
          deadline_of[free] = due;
          action_of[free]   = req.action;
          tag_of[free]      = req.tag;
          slot_taken[free]  = 1'b1;
          expected_results.push_back(result_of(ST_INSERTED, SLOT_W'(free), '0, '0, 1'b1));
        end
      end
      REQ_CANCEL: begin
        if (!slot_taken[req.handle]) begin
          expected_results.push_back(result_of(ST_NOTFOUND, '0, '0, '0, 1'b1));
        end else begin
          pos = 0;
          while (pos < queued && due_order[pos] != req.handle) pos++;
          if (pos < queued) begin
            for (i = pos; i + 1 < queued; i++) due_order[i] = due_order[i + 1];
            queued--;
          end
          slot_taken[req.handle] = 1'b0;
          expected_results.push_back(result_of(ST_CANCELLED, req.handle, '0, '0, 1'b1));
        end
      end
      REQ_TICK: begin
        now_ticks = now_ticks + 1;
        fires = 0;
        stop  = 1'b0;
        // Each fire is held back one step so the final one can carry the last flag.
        while (!stop && queued > 0 && fires < FIRE_LIMIT) begin
          head = due_order[0];
          if (due_earlier(now_ticks, deadline_of[head])) begin
            stop = 1'b1;
          end else begin
            if (fires > 0) expected_results.push_back(held);
            held = result_of(ST_FIRED, head, action_of[head], tag_of[head], 1'b0);
            fires++;
            slot_taken[head] = 1'b0;
            for (i = 0; i + 1 < queued; i++) due_order[i] = due_order[i + 1];
            queued--;
          end
        end
        if (fires == 0) begin
          expected_results.push_back(result_of(ST_NONEDUE, '0, '0, '0, 1'b1));
        end else begin
          held.last = 1'b1;
          expected_results.push_back(held);
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    checked_count++;
    if (expected_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: unexpected result: status %0d slot %0d action %h tag %h last %b",
                 $time, got.status, got.slot, got.fired_action, got.fired_tag, got.last);
    end else begin
      want = expected_results.pop_front();
      if (want.status == ST_FIRED) fired_count++;
      if (got.status !== want.status || got.slot !== want.slot ||
          got.fired_action !== want.fired_action || got.fired_tag !== want.fired_tag ||
          got.last !== want.last) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("%0t: result mismatch, expected status %0d slot %0d action %h tag %h last %b",
                   $time, want.status, want.slot, want.fired_action, want.fired_tag,
                   want.last);
          $display("%0t:                  actual   status %0d slot %0d action %h tag %h last %b",
                   $time, got.status, got.slot, got.fired_action, got.fired_tag, got.last);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      now_ticks      = '0;
      slot_taken     = '0;
      queued         = 0;
      mismatch_count = 0;
      checked_count  = 0;
      fired_count    = 0;
      expected_results.delete();
    end else begin
      // Results are checked before a new transfer is predicted in the same cycle.
      if (out_strobe === 1'b1) check_result(out_item);
      if (start && !busy) predict_results(in_item);
    end
    outstanding = expected_results.size();
  end

endmodule

@@ dv/tb_sorted_timer_event_queue.sv @@
module tb_sorted_timer_event_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import stq_pkg::*;

  localparam int         DEPTH         = QUEUE_DEPTH;
  localparam int         REQUEST_GOAL  = 430;
  localparam int         QUIET_TAIL    = 60;
  localparam int         SETTLE_CYCLES = 600;
  localparam logic [1:0] REQ_UNUSED    = 2'd3;

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_strobe;
  out_item_t out_item;

  int mismatch_count;
  int outstanding;
  int checked_count;
  int fired_count;
  int n_insert;
  int n_cancel;
  int n_tick;
  int n_ignored;
  int n_real;
  bit quiet;

  always #5 clk = ~clk;

  sorted_timer_event_queue DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  timer_queue_checker #(
    .DEPTH(DEPTH)
  ) queue_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_item       (in_item),
    .out_strobe    (out_strobe),
    .out_item      (out_item),
    .mismatch_count(mismatch_count),
    .outstanding   (outstanding),
    .checked_count (checked_count),
    .fired_count   (fired_count)
  );

  function automatic in_item_t request(input logic [1:0] kind, input logic [15:0] ticks,
                                       input logic [7:0] act, input logic [31:0] arg,
                                       input logic [SLOT_W-1:0] slot);
    in_item_t r;
    r.req_type = kind;
    r.interval = ticks;
    r.action   = act;
    r.tag      = arg;
    r.handle   = slot;
    return r;
  endfunction

  // Unused fields stay random so that every input bit toggles.
  function automatic in_item_t random_request();
    in_item_t r;
    int       pick;
    int       spread;
    r = request(REQ_TICK, 16'($urandom_range(0, 16'hFFFF)), 8'($urandom_range(0, 255)),
                $urandom, SLOT_W'($urandom_range(0, DEPTH - 1)));
    pick = $urandom_range(0, 99);
    if (pick < 42) begin
      r.req_type = REQ_INSERT;
      spread = $urandom_range(0, 99);
      if (spread < 70)      r.interval = 16'($urandom_range(1, 8));
      else if (spread < 85) r.interval = 16'($urandom_range(9, 200));
      else if (spread < 95) r.interval = 16'($urandom_range(1, 16'hFFFF));
      else                  r.interval = '0;
    end else if (pick < 58) begin
      r.req_type = REQ_CANCEL;
    end else if (pick >= 96) begin
      r.req_type = REQ_UNUSED;
    end
    return r;
  endfunction

  task automatic send(input in_item_t req);
    @(negedge clk);
    start   <= 1'b1;
    in_item <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    case (req.req_type)
      REQ_INSERT: n_insert++;
      REQ_CANCEL: n_cancel++;
      REQ_TICK:   n_tick++;
      default:    n_ignored++;
    endcase
    if (req.req_type != REQ_UNUSED) n_real++;
  endtask

  task automatic pause(input int cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic maybe_pause();
    if (!quiet && $urandom_range(0, 99) < 25) pause($urandom_range(1, 10));
  endtask

  // Hold off until the queue has answered every transfer so far.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // A burst of short timers, then ticks to fire them in deadline order.
  task automatic flood();
    repeat (18) begin
      maybe_pause();
      send(request(REQ_INSERT, 16'($urandom_range(1, 3)), 8'($urandom_range(0, 255)),
                   $urandom, SLOT_W'($urandom_range(0, DEPTH - 1))));
    end
    repeat (4) begin
      maybe_pause();
      send(request(REQ_TICK, '0, '0, '0, '0));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send(request(REQ_TICK, '0, '0, '0, '0));
    send(request(REQ_UNUSED, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 4'hF));
    send(request(REQ_INSERT, 16'h0000, 8'hA5, 32'h1234_5678, 4'hF));
    send(request(REQ_INSERT, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 4'hF));
    send(request(REQ_CANCEL, 16'h0000, 8'h00, 32'h0000_0000, 4'h0));
    send(request(REQ_CANCEL, 16'h0000, 8'h00, 32'h0000_0000, 4'h0));
    // Sixteen timers with one deadline: they must fire newest first on a single tick.
    for (int i = 0; i < DEPTH; i++)
      send(request(REQ_INSERT, 16'd2, 8'(i * 17), $urandom, 4'hF));
    send(request(REQ_INSERT, 16'd1, 8'h3C, 32'hDEAD_BEEF, 4'h0));
    send(request(REQ_INSERT, 16'd0, 8'h3C, 32'hDEAD_BEEF, 4'h0));
    send(request(REQ_TICK, '0, '0, '0, '0));
    send(request(REQ_TICK, '0, '0, '0, '0));
    drain();

    while (n_real < REQUEST_GOAL) begin
      quiet = (n_real >= REQUEST_GOAL - QUIET_TAIL);
      maybe_pause();
      if (!quiet && $urandom_range(0, 99) < 3) flood();
      else send(random_request());
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d inserts, %0d cancels, %0d ticks and %0d ignored requests;",
             n_insert, n_cancel, n_tick, n_ignored);
    $display("checked %0d results including %0d fired events, %0d mismatches.",
             checked_count, fired_count, mismatch_count);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("tb_sorted_timer_event_queue: PASS");
    end else begin
      $display("tb_sorted_timer_event_queue: FAIL");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("tb_sorted_timer_event_queue: FAIL");
    $finish;
  end

endmodule
